FILE: hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants for the path depth checker
// Segment classes, result status codes and the path characters of interest.
// ----------------------------------------------------------------------------
package pdc_pkg;

	// width of the reported depth field
	localparam int DEPTH_W = 12;

	// characters that steer segment parsing
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

	// class of the segment being scanned
	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_DOT    = 2'd1,
		KIND_DOTDOT = 2'd2,
		KIND_OTHER  = 2'd3
	} kind_t;

	// result status, also the sticky error code
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_REJECT   = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	// control part of the scanner state
	typedef struct packed {
		logic    at_start;
		kind_t   kind;
		status_t code;
	} scan_ctl_t;

endpackage

FILE: hdl/path_depth_checker_top.sv
// ----------------------------------------------------------------------------
// path_depth_checker_top: request path traversal checker
// Scans a path byte by byte and reports status and directory depth per path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one path byte per beat, with
//   is_final high on the last byte of a path. Output channel (out_valid /
//   out_stall) carries one beat per path: status (0 accepted, 1 rejected,
//   2 depth overflow) and depth (masked to 12 bits, 0 unless accepted).
//   Throughput: one byte per cycle unless in_stall; a byte is registered at
//   acceptance and folded into the scanner state by a single update stage.
//   The result beat is registered when the final byte leaves the input
//   register. A waiting result does not block non-final bytes of the next
//   path; only a final byte waits in the input register for the result
//   register to free, and then in_stall rises.
//   Reset (arst_n low) empties both registers and returns the scanner to
//   the start of a path at depth 0.
//   While out_stall is high the result beat holds steady.
// ----------------------------------------------------------------------------
module path_depth_checker_top #(
	parameter int MAX_DEPTH = 4095
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   path_byte,
	input  logic                         is_final,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [pdc_pkg::DEPTH_W-1:0]  depth
);
	import pdc_pkg::*;

	localparam int LVL_W = $clog2(MAX_DEPTH + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              final_s1;

	scan_ctl_t         ctl_q;
	logic [LVL_W-1:0]  level_q;
	scan_ctl_t         nxt_ctl;
	logic [LVL_W-1:0]  nxt_level;
	status_t           res_status;
	logic [DEPTH_W-1:0] res_depth;

	logic              out_valid_q;
	status_t           status_q;
	logic [DEPTH_W-1:0] depth_q;

	logic              out_free;
	logic              advance;
	logic              accept_in;

	// handshake: a final byte needs a free result register
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!final_s1 || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1  <= path_byte;
			final_s1 <= is_final;
		end
	end

	pdc_step #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_step (
		.cur_ctl    (ctl_q),
		.cur_level  (level_q),
		.path_byte  (byte_s1),
		.is_final   (final_s1),
		.nxt_ctl    (nxt_ctl),
		.nxt_level  (nxt_level),
		.res_status (res_status),
		.res_depth  (res_depth)
	);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.at_start <= 1'b1;
			ctl_q.kind     <= KIND_EMPTY;
			ctl_q.code     <= STATUS_OK;
			level_q        <= '0;
		end else if (advance) begin
			ctl_q   <= nxt_ctl;
			level_q <= nxt_level;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			status_q <= res_status;
			depth_q  <= res_depth;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign depth     = depth_q;

endmodule

FILE: hdl/pdc_step.sv
// ----------------------------------------------------------------------------
// pdc_step: per-byte scanner update
// Folds one path byte into the scanner state and forms the result on the
// final byte of a path.
// ----------------------------------------------------------------------------
module pdc_step #(
	parameter int MAX_DEPTH = 4095
) (
	input  pdc_pkg::scan_ctl_t                     cur_ctl,
	input  logic [$clog2(MAX_DEPTH+1)-1:0]         cur_level,
	input  logic [7:0]                             path_byte,
	input  logic                                   is_final,
	output pdc_pkg::scan_ctl_t                     nxt_ctl,
	output logic [$clog2(MAX_DEPTH+1)-1:0]         nxt_level,
	output pdc_pkg::status_t                       res_status,
	output logic [pdc_pkg::DEPTH_W-1:0]            res_depth
);
	import pdc_pkg::*;

	localparam int LVL_W = $clog2(MAX_DEPTH + 1);

	typedef struct packed {
		status_t            code;
		logic [LVL_W-1:0]   level;
	} close_t;

	// apply the effect of a completed segment to code and depth
	function automatic close_t close_seg(kind_t k, status_t c, logic [LVL_W-1:0] l);
		close_t r;
		r.code  = c;
		r.level = l;
		if (c == STATUS_OK) begin
			if (k == KIND_DOTDOT) begin
				if (l == '0) r.code = STATUS_REJECT;
				else r.level = l - 1'b1;
			end else if (k == KIND_OTHER) begin
				if (l >= LVL_W'(MAX_DEPTH)) r.code = STATUS_OVERFLOW;
				else r.level = l + 1'b1;
			end
		end
		return r;
	endfunction

	logic             at_v;
	kind_t            kind_v;
	status_t          code_v;
	logic [LVL_W-1:0] lvl_v;
	close_t           cl_byte;
	close_t           cl_fin;

	// byte update, then closing of the open segment on the final byte
	always_comb begin
		at_v       = cur_ctl.at_start;
		kind_v     = cur_ctl.kind;
		code_v     = cur_ctl.code;
		lvl_v      = cur_level;
		cl_byte    = close_seg(kind_v, code_v, lvl_v);
		res_status = STATUS_OK;
		res_depth  = '0;

		if (at_v) begin
			// first byte must be a slash, nothing else is done with it
			at_v = 1'b0;
			if (path_byte != CHAR_SLASH) code_v = STATUS_REJECT;
		end else if (code_v == STATUS_OK) begin
			if (path_byte == CHAR_SLASH) begin
				code_v = cl_byte.code;
				lvl_v  = cl_byte.level;
				kind_v = KIND_EMPTY;
			end else if (path_byte == CHAR_DOT) begin
				case (kind_v)
					KIND_EMPTY: kind_v = KIND_DOT;
					KIND_DOT:   kind_v = KIND_DOTDOT;
					default:    kind_v = KIND_OTHER;
				endcase
			end else begin
				kind_v = KIND_OTHER;
			end
		end

		cl_fin = close_seg(kind_v, code_v, lvl_v);

		if (is_final) begin
			res_status = cl_fin.code;
			res_depth  = (cl_fin.code == STATUS_OK) ? DEPTH_W'(cl_fin.level) : '0;
			// back to the start of a new path
			at_v   = 1'b1;
			kind_v = KIND_EMPTY;
			code_v = STATUS_OK;
			lvl_v  = '0;
		end

		nxt_ctl.at_start = at_v;
		nxt_ctl.kind     = kind_v;
		nxt_ctl.code     = code_v;
		nxt_level        = lvl_v;
	end

endmodule
